@@ rtl/rna_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rna_pkg
// Shared widths, opcodes, status codes and fsm state encoding for the rational number ALU.
// ----------------------------------------------------------------------------
package rna_pkg;

    localparam int DATA_W = 32;
    localparam int WIDTH  = 32;
    localparam int PW     = 2 * WIDTH;
    localparam int CNT_W  = $clog2(PW);

    localparam logic [PW-1:0] LIM = PW'(1) << (WIDTH - 1);

    localparam logic [3:0] CMD_ADD = 4'd0;
    localparam logic [3:0] CMD_SUB = 4'd1;
    localparam logic [3:0] CMD_MUL = 4'd2;
    localparam logic [3:0] CMD_DIV = 4'd3;
    localparam logic [3:0] CMD_LT  = 4'd4;
    localparam logic [3:0] CMD_GT  = 4'd5;
    localparam logic [3:0] CMD_EQ  = 4'd6;
    localparam logic [3:0] CMD_NE  = 4'd7;
    localparam logic [3:0] CMD_INC = 4'd8;
    localparam logic [3:0] CMD_DEC = 4'd9;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVF      = 2'd2;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL_P = 9'b000000010,
        S_MUL_Q = 9'b000000100,
        S_MUL_D = 9'b000001000,
        S_COMB  = 9'b000010000,
        S_GCD   = 9'b000100000,
        S_DIV_N = 9'b001000000,
        S_DIV_D = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

endpackage

@@ rtl/rational_number_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_number_alu
// Rational arithmetic and compare on signed fractions, with gcd reduction of add/sub/mul/div results.
// ----------------------------------------------------------------------------
// sequence: compares and inc/dec run only the multiply and combine steps, while
// add/sub/mul/div also run a binary gcd and two restoring divisions (numerator,
// then denominator, by the gcd) on the shared divider step
// throughput: one transaction at a time, next accepted once the fsm is idle
// reset: asynchronous active-low rst_n clears the fsm and output valid
module rational_number_alu (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [3:0]                  cmd,
    input  logic signed [rna_pkg::DATA_W-1:0] a_num,
    input  logic signed [rna_pkg::DATA_W-1:0] a_den,
    input  logic signed [rna_pkg::DATA_W-1:0] b_num,
    input  logic signed [rna_pkg::DATA_W-1:0] b_den,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [rna_pkg::DATA_W-1:0] res_num,
    output logic signed [rna_pkg::DATA_W-1:0] res_den,
    output logic                        cmp_true,
    output logic [1:0]                  status
);

    localparam int W  = rna_pkg::WIDTH;
    localparam int PW = rna_pkg::PW;
    localparam int CW = rna_pkg::CNT_W;
    localparam int DW = rna_pkg::DATA_W;

    rna_pkg::state_t state_reg, state_next;

    logic [3:0]    cmd_reg, cmd_next;
    logic [W-1:0]  m_an_reg, m_ad_reg, m_bn_reg, m_bd_reg;
    logic [W-1:0]  m_an_next, m_ad_next, m_bn_next, m_bd_next;
    logic          s_an_reg, s_ad_reg, s_bn_reg, s_bd_reg;
    logic          s_an_next, s_ad_next, s_bn_next, s_bd_next;
    logic [PW-1:0] p_reg, p_next, q_reg, q_next;
    logic [PW-1:0] num_reg, num_next, den_reg, den_next;
    logic [PW-1:0] u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [CW-1:0] k_reg, k_next, cnt_reg, cnt_next;
    logic          neg_reg, neg_next, arith_reg, arith_next, cmp_reg, cmp_next;
    logic [1:0]    stat_reg, stat_next;

    logic          out_valid_reg, out_valid_next;
    logic signed [DW-1:0] res_num_reg, res_num_next, res_den_reg, res_den_next;
    logic          cmp_true_reg, cmp_true_next;
    logic [1:0]    status_reg, status_next;

    logic [W-1:0]  op_an, op_ad, op_bn, op_bd;
    logic [W-1:0]  mul_x, mul_y;
    logic [PW-1:0] prod;
    logic          ps, qs, ds, rs_sign;
    logic [PW-1:0] sum_mag;
    logic          sum_neg, lt, eq;
    logic [PW:0]   div_sh;
    logic [PW-1:0] div_q;
    logic          div_ge;
    logic          n_neg;
    logic signed [W-1:0] n_w, d_w;
    logic          is_cmp;

    assign in_ready  = (state_reg == rna_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign cmp_true  = cmp_true_reg;
    assign status    = status_reg;

    assign op_an = a_num[W-1:0];
    assign op_ad = a_den[W-1:0];
    assign op_bn = b_num[W-1:0];
    assign op_bd = b_den[W-1:0];

    assign is_cmp = (cmd_reg == rna_pkg::CMD_LT) || (cmd_reg == rna_pkg::CMD_GT)
                 || (cmd_reg == rna_pkg::CMD_EQ) || (cmd_reg == rna_pkg::CMD_NE);

    // shared multiplier operand select
    always_comb
    begin
        mul_x = m_an_reg;
        mul_y = m_bd_reg;
        if (state_reg == rna_pkg::S_MUL_P)
        begin
            mul_x = m_an_reg;
            if (cmd_reg == rna_pkg::CMD_MUL)
                mul_y = m_bn_reg;
            else if (cmd_reg == rna_pkg::CMD_INC || cmd_reg == rna_pkg::CMD_DEC)
                mul_y = W'(1);
            else
                mul_y = m_bd_reg;
        end
        else if (state_reg == rna_pkg::S_MUL_Q)
        begin
            mul_x = m_ad_reg;
            if (cmd_reg == rna_pkg::CMD_INC || cmd_reg == rna_pkg::CMD_DEC)
                mul_y = W'(1);
            else
                mul_y = m_bn_reg;
        end
        else
        begin
            mul_x = m_ad_reg;
            if (cmd_reg == rna_pkg::CMD_DIV)
                mul_y = m_bn_reg;
            else if (cmd_reg == rna_pkg::CMD_INC || cmd_reg == rna_pkg::CMD_DEC)
                mul_y = W'(1);
            else
                mul_y = m_bd_reg;
        end
    end

    assign prod = PW'(mul_x) * PW'(mul_y);

    // sign of each product
    always_comb
    begin
        ps = s_an_reg ^ s_bd_reg;
        qs = s_bn_reg ^ s_ad_reg;
        ds = s_ad_reg ^ s_bd_reg;
        if (cmd_reg == rna_pkg::CMD_MUL)
            ps = s_an_reg ^ s_bn_reg;
        else if (cmd_reg == rna_pkg::CMD_INC || cmd_reg == rna_pkg::CMD_DEC || is_cmp)
            ps = s_an_reg ^ s_ad_reg;
        if (cmd_reg == rna_pkg::CMD_SUB)
            qs = ~(s_bn_reg ^ s_ad_reg);
        else if (cmd_reg == rna_pkg::CMD_INC)
            qs = 1'b0;
        else if (cmd_reg == rna_pkg::CMD_DEC)
            qs = 1'b1;
        else if (is_cmp)
            qs = s_bn_reg ^ s_bd_reg;
        if (cmd_reg == rna_pkg::CMD_DIV)
            ds = s_ad_reg ^ s_bn_reg;
        else if (cmd_reg == rna_pkg::CMD_INC || cmd_reg == rna_pkg::CMD_DEC)
            ds = 1'b0;
        if (p_reg == '0)
            ps = 1'b0;
        if (q_reg == '0)
            qs = 1'b0;
        if (den_reg == '0)
            ds = 1'b0;
    end

    // sign-magnitude add and compare
    always_comb
    begin
        if (ps == qs)
        begin
            sum_mag = p_reg + q_reg;
            sum_neg = ps;
        end
        else if (p_reg >= q_reg)
        begin
            sum_mag = p_reg - q_reg;
            sum_neg = ps;
        end
        else
        begin
            sum_mag = q_reg - p_reg;
            sum_neg = qs;
        end
        if (sum_mag == '0)
            sum_neg = 1'b0;
        eq = (ps == qs) && (p_reg == q_reg);
        if (ps != qs)
            lt = ps;
        else if (ps)
            lt = p_reg > q_reg;
        else
            lt = p_reg < q_reg;
    end

    // shared restoring divider step
    always_comb
    begin
        div_q  = (state_reg == rna_pkg::S_DIV_D) ? den_reg : num_reg;
        div_sh = {rem_reg, div_q[PW-1]};
        div_ge = (div_sh >= {1'b0, g_reg});
    end

    always_comb
    begin
        n_neg = neg_reg && (num_reg != '0);
        n_w   = n_neg ? -num_reg[W-1:0] : num_reg[W-1:0];
        d_w   = den_reg[W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        m_an_next      = m_an_reg;
        m_ad_next      = m_ad_reg;
        m_bn_next      = m_bn_reg;
        m_bd_next      = m_bd_reg;
        s_an_next      = s_an_reg;
        s_ad_next      = s_ad_reg;
        s_bn_next      = s_bn_reg;
        s_bd_next      = s_bd_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        g_next         = g_reg;
        rem_next       = rem_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        arith_next     = arith_reg;
        cmp_next       = cmp_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        cmp_true_next  = cmp_true_reg;
        status_next    = status_reg;
        rs_sign        = 1'b0;

        unique case (state_reg)
            rna_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    s_an_next  = op_an[W-1];
                    s_ad_next  = op_ad[W-1];
                    s_bn_next  = op_bn[W-1];
                    s_bd_next  = op_bd[W-1];
                    m_an_next  = op_an[W-1] ? -op_an : op_an;
                    m_ad_next  = op_ad[W-1] ? -op_ad : op_ad;
                    m_bn_next  = op_bn[W-1] ? -op_bn : op_bn;
                    m_bd_next  = op_bd[W-1] ? -op_bd : op_bd;
                    state_next = rna_pkg::S_MUL_P;
                end
            end
            rna_pkg::S_MUL_P:
            begin
                p_next     = prod;
                state_next = rna_pkg::S_MUL_Q;
            end
            rna_pkg::S_MUL_Q:
            begin
                q_next     = prod;
                state_next = rna_pkg::S_MUL_D;
            end
            rna_pkg::S_MUL_D:
            begin
                den_next   = prod;
                state_next = rna_pkg::S_COMB;
            end
            rna_pkg::S_COMB:
            begin
                k_next     = '0;
                cnt_next   = '0;
                rem_next   = '0;
                cmp_next   = 1'b0;
                state_next = rna_pkg::S_FIN;
                if (is_cmp)
                begin
                    arith_next = 1'b0;
                    neg_next   = 1'b0;
                    num_next   = '0;
                    if (m_ad_reg == '0 || m_bd_reg == '0)
                    begin
                        den_next  = '0;
                        stat_next = rna_pkg::ST_ZERO_DEN;
                    end
                    else
                    begin
                        den_next  = PW'(1);
                        stat_next = rna_pkg::ST_OK;
                        if (cmd_reg == rna_pkg::CMD_LT)
                            cmp_next = lt;
                        else if (cmd_reg == rna_pkg::CMD_GT)
                            cmp_next = !lt && !eq;
                        else if (cmd_reg == rna_pkg::CMD_EQ)
                            cmp_next = eq;
                        else
                            cmp_next = !eq;
                    end
                end
                else if (cmd_reg > rna_pkg::CMD_DEC)
                begin
                    arith_next = 1'b0;
                    neg_next   = 1'b0;
                    num_next   = '0;
                    den_next   = PW'(1);
                    stat_next  = rna_pkg::ST_OK;
                end
                else if (den_reg == '0)
                begin
                    arith_next = 1'b0;
                    neg_next   = 1'b0;
                    num_next   = '0;
                    stat_next  = rna_pkg::ST_ZERO_DEN;
                end
                else
                begin
                    arith_next = 1'b1;
                    stat_next  = rna_pkg::ST_OK;
                    if (cmd_reg == rna_pkg::CMD_MUL || cmd_reg == rna_pkg::CMD_DIV)
                    begin
                        num_next = p_reg;
                        rs_sign  = ps;
                    end
                    else
                    begin
                        num_next = sum_mag;
                        rs_sign  = sum_neg;
                    end
                    neg_next = rs_sign != ds;
                    u_next   = num_next;
                    v_next   = den_reg;
                    if (cmd_reg != rna_pkg::CMD_INC && cmd_reg != rna_pkg::CMD_DEC)
                        state_next = rna_pkg::S_GCD;
                end
            end
            rna_pkg::S_GCD:
            begin
                priority if (u_reg == '0)
                begin
                    g_next     = v_reg << k_reg;
                    state_next = rna_pkg::S_DIV_N;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + CW'(1);
                end
                else if (!u_reg[0])
                    u_next = u_reg >> 1;
                else if (!v_reg[0])
                    v_next = v_reg >> 1;
                else if (u_reg >= v_reg)
                    u_next = u_reg - v_reg;
                else
                    v_next = v_reg - u_reg;
            end
            rna_pkg::S_DIV_N, rna_pkg::S_DIV_D:
            begin
                rem_next = div_ge ? PW'(div_sh - {1'b0, g_reg}) : div_sh[PW-1:0];
                if (state_reg == rna_pkg::S_DIV_N)
                    num_next = {div_q[PW-2:0], div_ge};
                else
                    den_next = {div_q[PW-2:0], div_ge};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(PW - 1))
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    state_next = (state_reg == rna_pkg::S_DIV_N) ? rna_pkg::S_DIV_D
                                                                 : rna_pkg::S_FIN;
                end
            end
            rna_pkg::S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    cmp_true_next  = cmp_reg;
                    state_next     = rna_pkg::S_IDLE;
                    if (arith_reg && (den_reg > rna_pkg::LIM - PW'(1) ||
                        num_reg > (n_neg ? rna_pkg::LIM : rna_pkg::LIM - PW'(1))))
                    begin
                        res_num_next = '0;
                        res_den_next = '0;
                        status_next  = rna_pkg::ST_OVF;
                    end
                    else
                    begin
                        res_num_next = DW'(n_w);
                        res_den_next = DW'(d_w);
                        status_next  = stat_reg;
                    end
                end
            end
            default:
                state_next = rna_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rna_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        m_an_reg     <= m_an_next;
        m_ad_reg     <= m_ad_next;
        m_bn_reg     <= m_bn_next;
        m_bd_reg     <= m_bd_next;
        s_an_reg     <= s_an_next;
        s_ad_reg     <= s_ad_next;
        s_bn_reg     <= s_bn_next;
        s_bd_reg     <= s_bd_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        g_reg        <= g_next;
        rem_reg      <= rem_next;
        k_reg        <= k_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        arith_reg    <= arith_next;
        cmp_reg      <= cmp_next;
        stat_reg     <= stat_next;
        res_num_reg  <= res_num_next;
        res_den_reg  <= res_den_next;
        cmp_true_reg <= cmp_true_next;
        status_reg   <= status_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == rna_pkg::S_MUL_P)
        else $error("accepted transaction did not start the multiply steps");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rna_pkg::ST_OK |-> res_den > 0)
        else $error("ok result with non-positive denominator");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rna_pkg::ST_ZERO_DEN |->
            res_num == 0 && res_den == 0 && !cmp_true)
        else $error("zero denominator result not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmp_true |-> status == rna_pkg::ST_OK && res_num == 0)
        else $error("compare outcome with bad status");

endmodule
